@@ rtl/core/fwp_pkg.sv @@
// Shared types and codes of the inference work picker.
package fwp_pkg;

   // Stage codes of a table slot
   localparam logic [2:0] STAGE_ADMIT    = 3'd0;
   localparam logic [2:0] STAGE_PREFILL  = 3'd1;
   localparam logic [2:0] STAGE_DECODE   = 3'd2;
   localparam logic [2:0] STAGE_RELEASE  = 3'd3;
   localparam logic [2:0] STAGE_TERMINAL = 3'd4;

   // Item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_PLAN  = 1'b1;

   // Work kind codes
   localparam logic KIND_PREFILL = 1'b0;
   localparam logic KIND_DECODE  = 1'b1;

   localparam logic [31:0] BUDGET_RESET = 32'd512;

   typedef struct packed {
      logic        func;
      logic [5:0]  slot;
      logic        occupied;
      logic [31:0] request_id;
      logic [2:0]  stage_code;
      logic [31:0] prefill_pos;
      logic [31:0] decoded_tokens;
      logic [31:0] prompt_tokens;
   } req_type;

   typedef struct packed {
      logic [31:0] work_id;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic        work_kind;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [2:0]  stage;
      logic [31:0] prefilled;
      logic [31:0] decoded;
      logic [31:0] prompt;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN1,
      ST_SCAN2,
      ST_CALC,
      ST_DONE
   } picker_state_type;

endpackage

@@ rtl/core/fwp_range_calc.sv @@
// Token range calculation for the selected slot: one registered add, then compare and select.
module fwp_range_calc (
   input  logic              clock,
   input  logic              load,
   input  fwp_pkg::entry_type sel,
   input  logic [31:0]       budget,
   output fwp_pkg::rsp_type  result,
   output logic              ok
);
   import fwp_pkg::*;

   logic [32:0] sum_ff;
   logic        is_decode;
   logic        clipped;
   logic [31:0] pre_end;

   assign is_decode = (sel.stage == STAGE_DECODE);

   // Decode end is prompt plus decoded; prefill end is position plus budget, clipped to prompt
   always_ff @(posedge clock) begin
      if (load) begin
         if (is_decode) begin
            sum_ff <= {1'b0, sel.prompt} + {1'b0, sel.decoded};
         end else begin
            sum_ff <= {1'b0, sel.prefilled} + {1'b0, budget};
         end
      end
   end

   assign clipped = ({1'b0, sel.prompt} < sum_ff);
   assign pre_end = clipped ? sel.prompt : sum_ff[31:0];

   always_comb begin
      result.work_id = sel.id;
      if (is_decode) begin
         result.range_start = sum_ff[31:0] - 32'd1;
         result.range_end   = sum_ff[31:0];
         result.work_kind   = KIND_DECODE;
         ok = (sel.decoded != 32'd0) && !sum_ff[32];
      end else begin
         result.range_start = sel.prefilled;
         result.range_end   = pre_end;
         result.work_kind   = KIND_PREFILL;
         ok = (sel.prefilled < pre_end);
      end
   end

endmodule

@@ rtl/core/fifo_inference_work_picker.sv @@
// Top level of the inference work picker: slot table memories, scan sequencer, result register.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) carries write and plan items.
//    A write item stores one table slot; a write to a slot at or beyond SLOTS
//    is dropped.
//  - A plan item scans the table in slot order, one slot per cycle through the
//    registered-read table memories. A second pass runs only when the first
//    finds no prefill, decode or release slot with progress; the range
//    calculation follows the pass that selects a slot.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) delivers at most one work item
//    per plan; a plan that finds no work returns no transfer.
//  - csr_wr_en/csr_wr_data write the token budget (reset value 512); the user must write
//    it only while idle, as the block does not enforce this.
//  - Reset starts a clearing pass over the occupancy memory, with req_ready low during it.
//  - The result register holds a finished transfer while the receiver stalls;
//    the next item is accepted meanwhile, and a later plan waits in its final
//    step only until the register frees up.
module fifo_inference_work_picker #(
   parameter int SLOTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fwp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fwp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);
   import fwp_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(SLOTS);

   // Table memories: slot contents, and occupancy which reset clears
   entry_type slot_entry_mem [SLOTS];
   logic      slot_used_mem  [SLOTS];

   picker_state_type state_ff, state_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             found_ff, found_in;
   entry_type        sel_ff, sel_in;
   entry_type        entry_q_ff;
   logic             used_q_ff;
   logic [31:0]      budget_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic              req_take;
   logic              wr_take;
   logic [SLOT_W-1:0] wr_addr;
   logic [SLOT_W-1:0] rd_addr;
   logic              rd_en;
   logic              used_we;
   logic [SLOT_W-1:0] used_waddr;
   logic              used_wdata;
   entry_type         wr_entry;
   logic              calc_load;
   logic              rsp_load;
   rsp_type           calc_rsp;
   logic              calc_ok;
   logic              q_work;
   logic              q_release;
   logic              q_progress;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign wr_take   = req_take && (req_data.func == FUNC_WRITE)
                      && ({26'd0, req_data.slot} < 32'(SLOTS));
   assign wr_addr   = SLOT_W'(req_data.slot);
   assign rd_addr   = addr_ff[SLOT_W-1:0];

   assign wr_entry.id        = req_data.request_id;
   assign wr_entry.stage     = req_data.stage_code;
   assign wr_entry.prefilled = req_data.prefill_pos;
   assign wr_entry.decoded   = req_data.decoded_tokens;
   assign wr_entry.prompt    = req_data.prompt_tokens;

   always_ff @(posedge clock) begin
      if (wr_take) begin
         slot_entry_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         entry_q_ff <= slot_entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         slot_used_mem[used_waddr] <= used_wdata;
      end
      if (rd_en) begin
         used_q_ff <= slot_used_mem[rd_addr];
      end
   end

   // Classify the slot read last cycle; unknown stages count as neither
   assign q_work     = used_q_ff && ((entry_q_ff.stage == STAGE_PREFILL)
                                     || (entry_q_ff.stage == STAGE_DECODE));
   assign q_release  = used_q_ff && (entry_q_ff.stage == STAGE_RELEASE);
   assign q_progress = (entry_q_ff.prefilled != 32'd0) || (entry_q_ff.decoded != 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         rd_pend_ff <= rd_pend_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
   end

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      rd_pend_in = 1'b0;
      found_in   = found_ff;
      sel_in     = sel_ff;
      rd_en      = 1'b0;
      used_we    = 1'b0;
      used_waddr = wr_addr;
      used_wdata = req_data.occupied;
      calc_load  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff) inside
         ST_CLEAR: begin
            // Sweep occupancy to empty, one slot per cycle
            used_we    = 1'b1;
            used_waddr = addr_ff[SLOT_W-1:0];
            used_wdata = 1'b0;
            if (addr_ff == LAST_CNT) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            used_we = wr_take;
            if (req_take && (req_data.func == FUNC_PLAN)) begin
               state_in = ST_SCAN1;
               addr_in  = '0;
               found_in = 1'b0;
            end
         end
         ST_SCAN1, ST_SCAN2: begin
            // Issue the next slot read while judging the one that returned
            if (addr_ff != END_CNT) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               addr_in    = addr_ff + CNT_W'(1);
            end
            if (state_ff == ST_SCAN1) begin
               if (rd_pend_ff) begin
                  if (q_release && q_progress) begin
                     state_in = ST_IDLE;
                  end else if (!found_ff && q_work && q_progress) begin
                     found_in = 1'b1;
                     sel_in   = entry_q_ff;
                  end
               end else if (addr_ff == END_CNT) begin
                  state_in = found_ff ? ST_CALC : ST_SCAN2;
                  addr_in  = '0;
               end
            end else begin
               if (rd_pend_ff) begin
                  if (q_release) begin
                     state_in = ST_IDLE;
                  end else if (q_work) begin
                     sel_in   = entry_q_ff;
                     state_in = ST_CALC;
                  end
               end else if (addr_ff == END_CNT) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CALC: begin
            calc_load = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the result register can take the transfer; a result that is not ok is dropped
            if (!calc_ok) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   fwp_range_calc u_calc (
      .clock  (clock),
      .load   (calc_load),
      .sel    (sel_ff),
      .budget (budget_ff),
      .result (calc_rsp),
      .ok     (calc_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_wr_en) begin
         budget_ff <= csr_wr_data;
      end
   end

   // Output register: load a finished transfer, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= calc_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A new result appears only out of the final plan step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside final plan step");

   // The second pass runs only when the first found nothing
   a_scan2_unfound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN2) |-> !found_ff)
      else $error("second scan pass with a selection held");

   // The slot counter never runs past the table
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= END_CNT)
      else $error("slot counter beyond table");

   // A result is never overwritten while the receiver stalls
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
`endif

endmodule
